// ----- rtl/core/ila_pkg.sv -----
// Shared constants and types of the implicit-list heap allocator.
`default_nettype none
package ila_pkg;

  localparam int HEAP_BYTES_DEF       = 65536;
  localparam int INIT_CHUNK_BYTES_DEF = 4096;

  localparam int          WORD_W    = 32;
  localparam logic [31:0] SZ_MASK   = 32'hFFFF_FFF8;
  localparam logic [31:0] MIN_BLOCK = 32'd16;

  typedef enum logic [1:0] {
    FN_INIT  = 2'd0,
    FN_ALLOC = 2'd1,
    FN_FREE  = 2'd2,
    FN_NONE  = 2'd3
  } func_t;

  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

endpackage
`default_nettype wire

// ----- rtl/core/ila_alu.sv -----
// Shared 32-bit add/subtract unit used by the allocator sequencer.
`default_nettype none
module ila_alu (
  input  wire ila_pkg::alu_op_t                op,
  input  wire logic [ila_pkg::WORD_W-1:0] a,
  input  wire logic [ila_pkg::WORD_W-1:0] b,
  output logic      [ila_pkg::WORD_W-1:0] sum
);

  always_comb begin
    case (op)
      ila_pkg::ALU_ADD: sum = a + b;
      ila_pkg::ALU_SUB: sum = a - b;
      default:          sum = a + b;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/core/implicit_list_heap_allocator.sv -----
// Top level of the boundary-tag heap allocator with its word store.
// The allocator keeps a heap of HEAP_BYTES bytes in an on-chip word store and
// serves one request at a time: init, allocate (first or best fit under
// cfg_wdata) or free. Each request is worked through by a small sequencer that
// drives one shared add/subtract unit and the single store port (one read or
// one write per cycle, read data registered). Allocate walks the block
// headers (the fit search reads one header per block), then may grow, merge
// and split; free frees the block and merges it with free neighbours. The
// input stays stalled for the whole request; the result sits in an output
// register, so the next request can start while a finished result still
// waits to be taken. Unwritten store words are never cleared; no clearing
// pass runs after reset.
`default_nettype none
module implicit_list_heap_allocator #(
  parameter int HEAP_BYTES       = ila_pkg::HEAP_BYTES_DEF,
  parameter int INIT_CHUNK_BYTES = ila_pkg::INIT_CHUNK_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_request_size,
  input  wire logic [15:0] in_block_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_result_addr,
  output logic             out_ok
);

  localparam int WORDS  = HEAP_BYTES / 4;
  localparam int IDX_W  = $clog2(WORDS);
  localparam int BRK_W  = $clog2(HEAP_BYTES + 1);
  localparam int CHUNK  = (((INIT_CHUNK_BYTES / 4) * 4 + 7) / 8) * 8;
  localparam bit INIT_FITS = (16 + CHUNK) <= HEAP_BYTES;
  localparam logic [31:0] HEAP32  = 32'(HEAP_BYTES);
  localparam logic [31:0] CHUNK32 = 32'(CHUNK);

  typedef enum logic [19:0] {
    S_IDLE    = 20'h00001,
    S_INIT_W  = 20'h00002,
    S_GROW_CK = 20'h00004,
    S_GROW_W  = 20'h00008,
    S_MG_RDH  = 20'h00010,
    S_MG_RDF  = 20'h00020,
    S_MG_RDP  = 20'h00040,
    S_MG_RDN  = 20'h00080,
    S_MG_SUM1 = 20'h00100,
    S_MG_SUM2 = 20'h00200,
    S_MG_W    = 20'h00400,
    S_F_CHK   = 20'h00800,
    S_F_EVAL  = 20'h01000,
    S_C_RD    = 20'h02000,
    S_C_EV    = 20'h04000,
    S_C_W     = 20'h08000,
    S_FR_EV   = 20'h10000,
    S_FR_W    = 20'h20000,
    S_DONE    = 20'h40000,
    S_SPARE   = 20'h80000
  } st_t;

  typedef enum logic [1:0] {
    CTX_INIT  = 2'd0,
    CTX_ALLOC = 2'd1,
    CTX_FREE  = 2'd2
  } ctx_t;

  st_t  state_r, state_nxt;
  ctx_t ctx_r, ctx_nxt;

  logic             fit_r;
  logic             init_r, init_nxt;
  logic [BRK_W-1:0] brk_r, brk_nxt;
  logic [31:0]      bp_r, bp_nxt, prev_r, prev_nxt, next_r, next_nxt;
  logic [31:0]      sz_r, sz_nxt, psz_r, psz_nxt, nsz_r, nsz_nxt;
  logic [31:0]      tot_r, tot_nxt, need_r, need_nxt;
  logic [31:0]      best_r, best_nxt, bsz_r, bsz_nxt, rest_r, rest_nxt;
  logic             pa_r, pa_nxt, na_r, na_nxt;
  logic [1:0]       wcnt_r, wcnt_nxt;
  logic [15:0]      res_r, res_nxt;
  logic             ok_r, ok_nxt;
  logic             out_valid_r, out_valid_nxt, out_ok_r, out_ok_nxt;
  logic [15:0]      out_addr_r, out_addr_nxt;

  logic [31:0] mem [WORDS];
  logic [31:0] mem_q_r;
  logic [31:0] mem_a, mem_wd;
  logic        mem_we, mem_in;

  ila_pkg::alu_op_t alu_op;
  logic [31:0] alu_a, alu_b, alu_sum;

  logic [31:0] brk32, q_sz, ret_v, need_in;
  logic        q_al, ret_go, end_walk;

  ila_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  assign brk32   = 32'(brk_r);
  assign q_sz    = mem_q_r & ila_pkg::SZ_MASK;
  assign q_al    = mem_q_r[0];
  assign need_in = (32'(in_request_size) + 32'd15) & ila_pkg::SZ_MASK;
  assign mem_in  = mem_a < HEAP32;

  assign in_stall        = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_result_addr = out_addr_r;
  assign out_ok          = out_ok_r;

  always_comb begin
    state_nxt = state_r;
    ctx_nxt   = ctx_r;
    init_nxt  = init_r;
    brk_nxt   = brk_r;
    bp_nxt    = bp_r;
    prev_nxt  = prev_r;
    next_nxt  = next_r;
    sz_nxt    = sz_r;
    psz_nxt   = psz_r;
    nsz_nxt   = nsz_r;
    tot_nxt   = tot_r;
    need_nxt  = need_r;
    best_nxt  = best_r;
    bsz_nxt   = bsz_r;
    rest_nxt  = rest_r;
    pa_nxt    = pa_r;
    na_nxt    = na_r;
    wcnt_nxt  = wcnt_r;
    res_nxt   = res_r;
    ok_nxt    = ok_r;
    mem_a     = '0;
    mem_wd    = '0;
    mem_we    = 1'b0;
    alu_op    = ila_pkg::ALU_ADD;
    alu_a     = '0;
    alu_b     = '0;
    ret_go    = 1'b0;
    ret_v     = '0;
    end_walk  = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt  = out_addr_r;
    out_ok_nxt    = out_ok_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_nxt   = '0;
          ok_nxt    = 1'b0;
          state_nxt = S_DONE;
          case (in_func)
            ila_pkg::FN_INIT: begin
              init_nxt = 1'b0;
              brk_nxt  = '0;
              if (INIT_FITS) begin
                wcnt_nxt  = '0;
                state_nxt = S_INIT_W;
              end
            end
            ila_pkg::FN_ALLOC: begin
              if (init_r && in_request_size != 16'd0) begin
                need_nxt  = need_in;
                bp_nxt    = 32'd8;
                best_nxt  = '0;
                bsz_nxt   = '0;
                state_nxt = S_F_CHK;
              end
            end
            ila_pkg::FN_FREE: begin
              if (init_r) begin
                if (in_block_addr == 16'd0) begin
                  ok_nxt = 1'b1;
                end else if (in_block_addr[2:0] == 3'd0 && in_block_addr >= 16'd16 &&
                             32'(in_block_addr) < brk32) begin
                  // fetch the header ahead of the checks
                  mem_a     = 32'(in_block_addr) - 32'd4;
                  bp_nxt    = 32'(in_block_addr);
                  state_nxt = S_FR_EV;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_INIT_W: begin
        // padding, prologue header/footer, epilogue
        mem_we   = 1'b1;
        mem_a    = {28'd0, wcnt_r, 2'b00};
        mem_wd   = (wcnt_r == 2'd0) ? 32'd0 : (wcnt_r == 2'd3) ? 32'd1 : 32'd9;
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd3) begin
          brk_nxt   = BRK_W'(16);
          need_nxt  = CHUNK32;
          ctx_nxt   = CTX_INIT;
          state_nxt = S_GROW_CK;
        end
      end

      S_GROW_CK: begin
        alu_op = ila_pkg::ALU_SUB;
        alu_a  = HEAP32;
        alu_b  = brk32;
        if (brk32 > HEAP32 || need_r > alu_sum) begin
          ret_go = 1'b1;
          ret_v  = '0;
        end else begin
          bp_nxt    = brk32;
          wcnt_nxt  = '0;
          state_nxt = S_GROW_W;
        end
      end

      S_GROW_W: begin
        alu_a    = bp_r;
        alu_b    = need_r;
        mem_we   = 1'b1;
        wcnt_nxt = wcnt_r + 2'd1;
        case (wcnt_r)
          2'd0: begin
            mem_a  = bp_r - 32'd4;
            mem_wd = need_r;
          end
          2'd1: begin
            mem_a  = alu_sum - 32'd8;
            mem_wd = need_r;
          end
          default: begin
            // new epilogue; advance the break
            mem_a     = alu_sum - 32'd4;
            mem_wd    = 32'd1;
            brk_nxt   = BRK_W'(alu_sum);
            state_nxt = S_MG_RDH;
          end
        endcase
      end

      S_MG_RDH: begin
        mem_a     = bp_r - 32'd4;
        state_nxt = S_MG_RDF;
      end

      S_MG_RDF: begin
        sz_nxt    = q_sz;
        mem_a     = bp_r - 32'd8;
        state_nxt = S_MG_RDP;
      end

      S_MG_RDP: begin
        alu_op    = ila_pkg::ALU_SUB;
        alu_a     = bp_r;
        alu_b     = q_sz;
        prev_nxt  = alu_sum;
        next_nxt  = bp_r + sz_r;
        mem_a     = alu_sum - 32'd4;
        state_nxt = S_MG_RDN;
      end

      S_MG_RDN: begin
        pa_nxt    = q_al;
        psz_nxt   = q_sz;
        mem_a     = next_r - 32'd4;
        state_nxt = S_MG_SUM1;
      end

      S_MG_SUM1: begin
        na_nxt  = q_al;
        nsz_nxt = q_sz;
        alu_a   = sz_r;
        alu_b   = pa_r ? 32'd0 : psz_r;
        tot_nxt = alu_sum;
        if (pa_r && q_al) begin
          ret_go = 1'b1;
          ret_v  = bp_r;
        end else begin
          state_nxt = S_MG_SUM2;
        end
      end

      S_MG_SUM2: begin
        alu_a     = tot_r;
        alu_b     = na_r ? 32'd0 : nsz_r;
        tot_nxt   = alu_sum;
        wcnt_nxt  = '0;
        state_nxt = S_MG_W;
      end

      S_MG_W: begin
        mem_we   = 1'b1;
        mem_wd   = tot_r;
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd0) begin
          if (pa_r)      mem_a = bp_r - 32'd4;
          else if (na_r) mem_a = bp_r + sz_r - 32'd8;
          else           mem_a = next_r + nsz_r - 32'd8;
        end else begin
          mem_a  = pa_r ? (bp_r + tot_r - 32'd8) : (prev_r - 32'd4);
          ret_go = 1'b1;
          ret_v  = pa_r ? bp_r : prev_r;
        end
      end

      S_F_CHK: begin
        if (bp_r < brk32) begin
          mem_a     = bp_r - 32'd4;
          state_nxt = S_F_EVAL;
        end else begin
          end_walk = 1'b1;
        end
      end

      S_F_EVAL: begin
        alu_a = bp_r;
        alu_b = q_sz;
        if (q_sz == 32'd0) begin
          end_walk = 1'b1;
        end else if (!q_al && q_sz >= need_r && !fit_r) begin
          state_nxt = S_C_RD;
        end else begin
          if (!q_al && q_sz >= need_r && (best_r == 32'd0 || q_sz < bsz_r)) begin
            best_nxt = bp_r;
            bsz_nxt  = q_sz;
          end
          bp_nxt    = alu_sum;
          state_nxt = S_F_CHK;
        end
      end

      S_C_RD: begin
        mem_a     = bp_r - 32'd4;
        state_nxt = S_C_EV;
      end

      S_C_EV: begin
        alu_op    = ila_pkg::ALU_SUB;
        alu_a     = q_sz;
        alu_b     = need_r;
        sz_nxt    = q_sz;
        rest_nxt  = alu_sum;
        wcnt_nxt  = '0;
        state_nxt = S_C_W;
      end

      S_C_W: begin
        mem_we   = 1'b1;
        wcnt_nxt = wcnt_r + 2'd1;
        if (rest_r >= ila_pkg::MIN_BLOCK) begin
          // split: allocated front, free remainder
          case (wcnt_r)
            2'd0: begin
              mem_a  = bp_r - 32'd4;
              mem_wd = need_r | 32'd1;
            end
            2'd1: begin
              mem_a  = bp_r + need_r - 32'd8;
              mem_wd = need_r | 32'd1;
            end
            2'd2: begin
              mem_a  = bp_r + need_r - 32'd4;
              mem_wd = rest_r;
            end
            default: begin
              mem_a  = bp_r + sz_r - 32'd8;
              mem_wd = rest_r;
            end
          endcase
        end else begin
          mem_a  = (wcnt_r == 2'd0) ? (bp_r - 32'd4) : (bp_r + sz_r - 32'd8);
          mem_wd = sz_r | 32'd1;
        end
        if ((rest_r >= ila_pkg::MIN_BLOCK && wcnt_r == 2'd3) ||
            (rest_r < ila_pkg::MIN_BLOCK && wcnt_r == 2'd1)) begin
          res_nxt   = bp_r[15:0];
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      end

      S_FR_EV: begin
        alu_op = ila_pkg::ALU_SUB;
        alu_a  = brk32;
        alu_b  = bp_r;
        if (q_al && q_sz >= ila_pkg::MIN_BLOCK && q_sz <= alu_sum) begin
          sz_nxt    = q_sz;
          wcnt_nxt  = '0;
          state_nxt = S_FR_W;
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_FR_W: begin
        mem_we   = 1'b1;
        mem_wd   = sz_r;
        mem_a    = (wcnt_r == 2'd0) ? (bp_r - 32'd4) : (bp_r + sz_r - 32'd8);
        wcnt_nxt = wcnt_r + 2'd1;
        if (wcnt_r == 2'd1) begin
          ctx_nxt   = CTX_FREE;
          state_nxt = S_MG_RDH;
        end
      end

      S_DONE: begin
        // hold while the previous result is still waiting
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_addr_nxt  = res_r;
          out_ok_nxt    = ok_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // end of the fit walk: take the best block or grow the heap
    if (end_walk) begin
      if (best_r != 32'd0) begin
        bp_nxt    = best_r;
        state_nxt = S_C_RD;
      end else begin
        ctx_nxt   = CTX_ALLOC;
        state_nxt = S_GROW_CK;
      end
    end

    // return from grow/merge to the calling operation
    if (ret_go) begin
      case (ctx_r)
        CTX_INIT: begin
          init_nxt  = (ret_v != 32'd0);
          ok_nxt    = (ret_v != 32'd0);
          state_nxt = S_DONE;
        end
        CTX_ALLOC: begin
          if (ret_v == 32'd0) begin
            state_nxt = S_DONE;
          end else begin
            bp_nxt    = ret_v;
            state_nxt = S_C_RD;
          end
        end
        default: begin
          ok_nxt    = 1'b1;
          state_nxt = S_DONE;
        end
      endcase
    end
  end

  // word store: one port, registered read, out-of-range reads give zero
  always_ff @(posedge clk) begin
    if (mem_we && mem_in) begin
      mem[mem_a[IDX_W+1:2]] <= mem_wd;
    end
    mem_q_r <= mem_in ? mem[mem_a[IDX_W+1:2]] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ctx_r       <= CTX_INIT;
      fit_r       <= 1'b0;
      init_r      <= 1'b0;
      brk_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ctx_r       <= ctx_nxt;
      init_r      <= init_nxt;
      brk_r       <= brk_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        fit_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    bp_r       <= bp_nxt;
    prev_r     <= prev_nxt;
    next_r     <= next_nxt;
    sz_r       <= sz_nxt;
    psz_r      <= psz_nxt;
    nsz_r      <= nsz_nxt;
    tot_r      <= tot_nxt;
    need_r     <= need_nxt;
    best_r     <= best_nxt;
    bsz_r      <= bsz_nxt;
    rest_r     <= rest_nxt;
    pa_r       <= pa_nxt;
    na_r       <= na_nxt;
    wcnt_r     <= wcnt_nxt;
    res_r      <= res_nxt;
    ok_r       <= ok_nxt;
    out_addr_r <= out_addr_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_brk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(brk_r) <= HEAP32)
    else $error("break beyond heap");

  a_init_brk: assert property (@(posedge clk) disable iff (!rst_n)
    init_r |-> (32'(brk_r) >= CHUNK32 + 32'd16))
    else $error("initialised heap below first chunk");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mem_we)
    else $error("store write while idle");

  a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_valid_r) |=> out_valid_r)
    else $error("finished result not presented");

endmodule
`default_nettype wire
